// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top RTL file of the delimiter splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds on every clock edge outside reset
`define TDS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Cause in one cycle, effect in the next
`define TDS_ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cause) |=> (effect)) else $error(msg);

`endif

// ===== rtl/tds_pkg.sv =====
// Shared types, character codes and helpers for the template delimiter splitter.
package tds_pkg;

    localparam int LINE_BITS_DEF = 24;
    localparam int START_LINE_W  = 24;
    localparam int MAX_RES       = 3;

    localparam logic [7:0] CH_LT  = 8'h3C;
    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef enum logic [1:0] {
        MODE_TEXT,
        MODE_START,
        MODE_CODE
    } mode_t;

    typedef logic [1:0] res_cnt_t;

    // One result record as it leaves the block
    typedef struct packed {
        logic                    has_byte;
        logic [7:0]              content_byte;
        logic                    is_code;
        logic [7:0]              command_char;
        logic                    block_end;
        logic [START_LINE_W-1:0] start_line;
        logic                    last_of_run;
    } result_t;

    // Space, tab, LF, VT, FF, CR
    function automatic logic is_ws(input logic [7:0] b);
        is_ws = (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

// ===== rtl/tds_decode.sv =====
// Splitter state and the per-byte rules that turn one byte into up to three results.
module tds_decode #(
    parameter int LINE_BITS = tds_pkg::LINE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [7:0]                    in_byte,
    input  logic                          in_last,
    input  logic                          consume,
    output tds_pkg::result_t [2:0]        res_slot,
    output tds_pkg::res_cnt_t             res_count
);

    tds_pkg::mode_t       mode_reg, mode_next;
    logic                 held_reg, held_next;
    logic                 nonempty_reg, nonempty_next;
    logic [7:0]           cmd_reg, cmd_next;
    logic [LINE_BITS-1:0] line_count_reg, line_count_next;
    logic [LINE_BITS-1:0] open_line_reg, open_line_next;
    logic [7:0]           prev_byte_reg, prev_byte_next;
    logic                 pair_closed_reg, pair_closed_next;

    // Decision flags for the current byte
    logic is_nl, pair_hit;
    logic open_hit, close_hit, release_hit, hold_hit, emit_b;
    logic nonempty_mid, nonempty_after;
    logic e1, e2, e3;
    logic [31:0] open_line_wide;
    logic [tds_pkg::START_LINE_W-1:0] open_line_24, old_line_24;
    logic [31:0] old_line_wide;

    // Line counting and delimiter decisions
    always_comb begin
        is_nl    = (in_byte == tds_pkg::CH_LF) || (in_byte == tds_pkg::CH_CR);
        pair_hit = is_nl && !pair_closed_reg &&
                   (((in_byte == tds_pkg::CH_LF) && (prev_byte_reg == tds_pkg::CH_CR)) ||
                    ((in_byte == tds_pkg::CH_CR) && (prev_byte_reg == tds_pkg::CH_LF)));
        line_count_next = line_count_reg;
        if (is_nl && !pair_hit && (line_count_reg != '1)) begin
            line_count_next = line_count_reg + 1'b1;
        end

        open_hit    = 1'b0;
        close_hit   = 1'b0;
        release_hit = 1'b0;
        hold_hit    = 1'b0;
        emit_b      = 1'b0;
        case (mode_reg)
            tds_pkg::MODE_TEXT: begin
                open_hit    = held_reg && (in_byte == tds_pkg::CH_PCT);
                release_hit = held_reg && (in_byte != tds_pkg::CH_PCT);
                hold_hit    = !open_hit && (in_byte == tds_pkg::CH_LT) && !in_last;
                emit_b      = !open_hit && !hold_hit;
            end
            tds_pkg::MODE_START: begin
                // a whitespace byte is content, anything else the command
                emit_b = tds_pkg::is_ws(in_byte);
            end
            tds_pkg::MODE_CODE: begin
                close_hit   = held_reg && (in_byte == tds_pkg::CH_GT);
                release_hit = held_reg && (in_byte != tds_pkg::CH_GT);
                hold_hit    = !close_hit && (in_byte == tds_pkg::CH_PCT) && !in_last;
                emit_b      = !close_hit && !hold_hit;
            end
            default: begin
                emit_b = 1'b0;
            end
        endcase

        nonempty_mid   = (open_hit || close_hit) ? 1'b0 :
                         (release_hit ? 1'b1 : nonempty_reg);
        nonempty_after = emit_b ? 1'b1 : nonempty_mid;
    end

    // Next state
    always_comb begin
        mode_next        = mode_reg;
        cmd_next         = cmd_reg;
        open_line_next   = open_line_reg;
        case (mode_reg)
            tds_pkg::MODE_TEXT: begin
                if (open_hit) begin
                    mode_next      = tds_pkg::MODE_START;
                    open_line_next = line_count_next;
                end
            end
            tds_pkg::MODE_START: begin
                mode_next = tds_pkg::MODE_CODE;
                cmd_next  = tds_pkg::is_ws(in_byte) ? 8'h00 : in_byte;
            end
            tds_pkg::MODE_CODE: begin
                if (close_hit) begin
                    mode_next = tds_pkg::MODE_TEXT;
                    cmd_next  = 8'h00;
                end
            end
            default: begin
                mode_next = tds_pkg::MODE_TEXT;
            end
        endcase
        held_next        = hold_hit;
        nonempty_next    = nonempty_after;
        prev_byte_next   = in_byte;
        pair_closed_next = pair_hit;
    end

    // Result records: release or end mark, then the byte, then the stream-end mark
    always_comb begin
        tds_pkg::result_t r1, r2, r3;

        old_line_wide  = 32'(open_line_reg);
        old_line_24    = old_line_wide[tds_pkg::START_LINE_W-1:0];
        open_line_wide = 32'(open_line_next);
        open_line_24   = open_line_wide[tds_pkg::START_LINE_W-1:0];

        e1 = release_hit || ((open_hit || close_hit) && nonempty_reg);
        e2 = emit_b;
        e3 = in_last && nonempty_after;

        r1.has_byte     = release_hit;
        r1.content_byte = !release_hit ? 8'h00 :
                          ((mode_reg == tds_pkg::MODE_TEXT) ? tds_pkg::CH_LT : tds_pkg::CH_PCT);
        r1.is_code      = (mode_reg != tds_pkg::MODE_TEXT);
        r1.command_char = r1.is_code ? cmd_reg : 8'h00;
        r1.block_end    = !release_hit;
        r1.start_line   = r1.is_code ? old_line_24 : '0;
        r1.last_of_run  = !e2 && !e3;

        r2.has_byte     = 1'b1;
        r2.content_byte = in_byte;
        r2.is_code      = (mode_reg != tds_pkg::MODE_TEXT);
        r2.command_char = r2.is_code ? cmd_next : 8'h00;
        r2.block_end    = 1'b0;
        r2.start_line   = r2.is_code ? open_line_24 : '0;
        r2.last_of_run  = !e3;

        r3.has_byte     = 1'b0;
        r3.content_byte = 8'h00;
        r3.is_code      = (mode_next != tds_pkg::MODE_TEXT);
        r3.command_char = r3.is_code ? cmd_next : 8'h00;
        r3.block_end    = 1'b1;
        r3.start_line   = r3.is_code ? open_line_24 : '0;
        r3.last_of_run  = 1'b1;

        // pack the present records toward slot 0
        res_slot[0] = e1 ? r1 : (e2 ? r2 : r3);
        res_slot[1] = e1 ? (e2 ? r2 : r3) : r3;
        res_slot[2] = r3;
        res_count   = tds_pkg::res_cnt_t'({1'b0, e1} + {1'b0, e2} + {1'b0, e3});
    end

    // State registers; stream end returns everything to reset values
    always_ff @(posedge aclk) begin
        if (!aresetn || (consume && in_last)) begin
            mode_reg        <= tds_pkg::MODE_TEXT;
            held_reg        <= 1'b0;
            nonempty_reg    <= 1'b0;
            cmd_reg         <= 8'h00;
            line_count_reg  <= LINE_BITS'(1);
            open_line_reg   <= LINE_BITS'(1);
            prev_byte_reg   <= 8'h00;
            pair_closed_reg <= 1'b0;
        end else if (consume) begin
            mode_reg        <= mode_next;
            held_reg        <= held_next;
            nonempty_reg    <= nonempty_next;
            cmd_reg         <= cmd_next;
            line_count_reg  <= line_count_next;
            open_line_reg   <= open_line_next;
            prev_byte_reg   <= prev_byte_next;
            pair_closed_reg <= pair_closed_next;
        end
    end

endmodule

// ===== rtl/tds_obuf.sv =====
// Result register: holds up to three results of one byte and hands them out in order.
module tds_obuf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   load,
    input  tds_pkg::result_t [2:0] load_slot,
    input  tds_pkg::res_cnt_t      load_count,
    input  logic                   m_ready,
    output logic                   m_valid,
    output tds_pkg::result_t       head,
    output logic                   free
);

    tds_pkg::result_t [2:0] slot_reg, slot_next;
    tds_pkg::res_cnt_t      count_reg, count_next;
    logic                   take;

    assign m_valid = (count_reg != '0);
    assign head    = slot_reg[0];
    assign take    = m_valid && m_ready;
    // room for a new group once the last pending result goes out
    assign free    = (count_reg == '0) || ((count_reg == tds_pkg::res_cnt_t'(1)) && m_ready);

    // Load a new group or shift toward the head on a transfer
    always_comb begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (load) begin
            slot_next  = load_slot;
            count_next = load_count;
        end else if (take) begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            count_next   = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/template_delimiter_splitter.sv =====
// The input register takes each byte; once the byte is consumed, its results are loaded into the result register,
// which presents them on the m_ side. Throughput: one byte per cycle while each byte gives at most one result and
// m_ready is high; a byte with up to three results holds the result register as its single read port hands them out.
// A byte that gives no result passes the input register without waiting on the m_ side.
// Reset (aresetn low at a rising edge) empties both registers and returns to text mode, line 1.
// The byte marked stream_end also returns all splitter state to its reset values.
`include "assert_macros.svh"

module template_delimiter_splitter #(
    parameter int LINE_BITS = tds_pkg::LINE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_stream_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_has_byte,
    output logic [7:0]                          m_content_byte,
    output logic                                m_is_code,
    output logic [7:0]                          m_command_char,
    output logic                                m_block_end,
    output logic [tds_pkg::START_LINE_W-1:0]    m_start_line,
    output logic                                m_last_of_run
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;
    logic                   consume;
    logic                   buf_free;
    tds_pkg::result_t [2:0] res_slot;
    tds_pkg::res_cnt_t      res_count;
    tds_pkg::result_t       head;

    // Input register: takes a transfer when empty or emptying
    assign consume = in_valid_reg && (buf_free || (res_count == '0));
    assign s_ready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_stream_end;
        end
    end

    tds_decode #(
        .LINE_BITS (LINE_BITS)
    ) u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_byte   (in_byte_reg),
        .in_last   (in_last_reg),
        .consume   (consume),
        .res_slot  (res_slot),
        .res_count (res_count)
    );

    tds_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (consume && (res_count != '0)),
        .load_slot  (res_slot),
        .load_count (res_count),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .head       (head),
        .free       (buf_free)
    );

    // Result fields
    assign m_has_byte     = head.has_byte;
    assign m_content_byte = head.content_byte;
    assign m_is_code      = head.is_code;
    assign m_command_char = head.command_char;
    assign m_block_end    = head.block_end;
    assign m_start_line   = head.start_line;
    assign m_last_of_run  = head.last_of_run;

    // Checks
    `TDS_ASSERT_ALWAYS(a_byte_xor_end, !m_valid || (m_has_byte ^ m_block_end), "result must be a byte or an end mark")
    `TDS_ASSERT_ALWAYS(a_text_clean, !(m_valid && !m_is_code) || ((m_command_char == 8'h00) && (m_start_line == '0)), "text result carries code fields")
    `TDS_ASSERT_NEXT(a_load_shows, consume && (res_count != '0), m_valid, "loaded results not presented")

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the template delimiter splitter: scoreboard class and stimulus.
`timescale 1ns / 100ps

module tb_top;

    // Line counter width as built by default
    localparam int LINE_W = tds_pkg::LINE_BITS_DEF;
    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};

    localparam int DIR_N        = 28;
    localparam int RANDOM_ITEMS = 190;
    localparam int DENSE_LEN    = 24;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS   = 1000000;
    localparam int REPORT_MAX   = 10;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic [7:0]                       s_data_byte;
    logic                             s_stream_end;
    logic                             m_valid;
    logic                             m_ready;
    logic                             m_has_byte;
    logic [7:0]                       m_content_byte;
    logic                             m_is_code;
    logic [7:0]                       m_command_char;
    logic                             m_block_end;
    logic [tds_pkg::START_LINE_W-1:0] m_start_line;
    logic                             m_last_of_run;

    template_delimiter_splitter #(
        .LINE_BITS(LINE_W)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_stream_end  (s_stream_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_has_byte    (m_has_byte),
        .m_content_byte(m_content_byte),
        .m_is_code     (m_is_code),
        .m_command_char(m_command_char),
        .m_block_end   (m_block_end),
        .m_start_line  (m_start_line),
        .m_last_of_run (m_last_of_run)
    );

    // Splitter state mirror and queue of expected result records
    class splitter_scoreboard;
        tds_pkg::mode_t    mode;
        bit                held;
        bit                nonempty;
        logic [7:0]        cmd;
        logic [LINE_W-1:0] line_cnt;
        logic [LINE_W-1:0] open_line;
        logic [7:0]        prev;
        bit                pair_closed;
        tds_pkg::result_t  run[$];
        tds_pkg::result_t  expected_results[$];
        int                errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode        = tds_pkg::MODE_TEXT;
            held        = 1'b0;
            nonempty    = 1'b0;
            cmd         = 8'h00;
            line_cnt    = 1;
            open_line   = 1;
            prev        = 8'h00;
            pair_closed = 1'b0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // One record in the current mode; a content byte marks the block non-empty
        function void add_result(bit has, logic [7:0] b, bit blk_end);
            tds_pkg::result_t r;
            bit               code;
            code           = (mode != tds_pkg::MODE_TEXT);
            r.has_byte     = has;
            r.content_byte = b;
            r.is_code      = code;
            r.command_char = code ? cmd : 8'h00;
            r.block_end    = blk_end;
            r.start_line   = code ? open_line : '0;
            r.last_of_run  = 1'b0;
            run.push_back(r);
            if (has)
                nonempty = 1'b1;
        endfunction

        // Work out the records caused by one transferred byte
        function void predict_results(logic [7:0] b, logic last);
            bit               plain;
            logic [7:0]       other;
            tds_pkg::result_t r;
            plain = 1'b1;
            run.delete();

            // line breaks: CR LF / LF CR pair counts once, counter saturates
            if (b == tds_pkg::CH_LF || b == tds_pkg::CH_CR) begin
                other = (b == tds_pkg::CH_CR) ? tds_pkg::CH_LF : tds_pkg::CH_CR;
                if (!pair_closed && prev == other) begin
                    pair_closed = 1'b1;
                end else begin
                    pair_closed = 1'b0;
                    if (line_cnt != LINE_MAX)
                        line_cnt++;
                end
            end else begin
                pair_closed = 1'b0;
            end
            prev = b;

            if (mode == tds_pkg::MODE_TEXT) begin
                if (held) begin
                    held = 1'b0;
                    if (b == tds_pkg::CH_PCT) begin
                        if (nonempty)
                            add_result(1'b0, 8'h00, 1'b1);
                        nonempty  = 1'b0;
                        mode      = tds_pkg::MODE_START;
                        open_line = line_cnt;
                        plain     = 1'b0;
                    end else begin
                        add_result(1'b1, tds_pkg::CH_LT, 1'b0);
                    end
                end
                if (plain) begin
                    if (b == tds_pkg::CH_LT && !last)
                        held = 1'b1;
                    else
                        add_result(1'b1, b, 1'b0);
                end
            end else begin
                if (mode == tds_pkg::MODE_START) begin
                    // first byte after the opener: command char unless whitespace
                    mode = tds_pkg::MODE_CODE;
                    if (b == tds_pkg::CH_SP || (b >= tds_pkg::CH_TAB && b <= tds_pkg::CH_CR)) begin
                        cmd = 8'h00;
                    end else begin
                        cmd   = b;
                        plain = 1'b0;
                    end
                end else if (held) begin
                    held = 1'b0;
                    if (b == tds_pkg::CH_GT) begin
                        if (nonempty)
                            add_result(1'b0, 8'h00, 1'b1);
                        nonempty = 1'b0;
                        mode     = tds_pkg::MODE_TEXT;
                        cmd      = 8'h00;
                        plain    = 1'b0;
                    end else begin
                        add_result(1'b1, tds_pkg::CH_PCT, 1'b0);
                    end
                end
                if (plain) begin
                    if (b == tds_pkg::CH_PCT && !last)
                        held = 1'b1;
                    else
                        add_result(1'b1, b, 1'b0);
                end
            end

            // stream end flushes the open block and restarts from reset state
            if (last) begin
                if (nonempty)
                    add_result(1'b0, 8'h00, 1'b1);
                clear_state();
            end

            foreach (run[i]) begin
                r = run[i];
                r.last_of_run = (i == run.size() - 1);
                expected_results.push_back(r);
            end
        endfunction

        function void field_check(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (exp_val !== act_val) begin
                if (errors < REPORT_MAX)
                    $display("%0t: %s mismatch: expected %0h, actual %0h",
                             $realtime, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(tds_pkg::result_t got);
            tds_pkg::result_t exp_r;
            if (expected_results.size() == 0) begin
                if (errors < REPORT_MAX)
                    $display("%0t: unexpected result %h with nothing pending",
                             $realtime, got);
                errors++;
                return;
            end
            exp_r = expected_results.pop_front();
            field_check("has_byte",     exp_r.has_byte,     got.has_byte);
            field_check("content_byte", exp_r.content_byte, got.content_byte);
            field_check("is_code",      exp_r.is_code,      got.is_code);
            field_check("command_char", exp_r.command_char, got.command_char);
            field_check("block_end",    exp_r.block_end,    got.block_end);
            field_check("start_line",   exp_r.start_line,   got.start_line);
            field_check("last_of_run",  exp_r.last_of_run,  got.last_of_run);
        endfunction
    endclass

    splitter_scoreboard sb = new();

    int               items_sent;
    int               burst_left;
    int               gap_max;
    int               stream_len;
    int               stream_cnt;
    bit               long_hold_req;
    tds_pkg::result_t seen;
    logic [7:0]       dir_bytes [DIR_N];

    // Clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Transfer monitor on both channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen = {m_has_byte, m_content_byte, m_is_code, m_command_char,
                        m_block_end, m_start_line, m_last_of_run};
                sb.check_result(seen);
            end
            if (s_valid && s_ready)
                sb.predict_results(s_data_byte, s_stream_end);
        end
    end

    // Result side: rotating 16-bit ready masks, plus one long hold-off on request
    initial begin : receiver
        logic [15:0] ready_mask;
        int          ready_phase;
        m_ready     = 1'b0;
        ready_mask  = '1;
        ready_phase = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                long_hold_req = 1'b0;
            end else begin
                if (ready_phase == 0) begin
                    ready_phase = 16;
                    case ($urandom_range(0, 3))
                        0: ready_mask = '1;
                        1: ready_mask = 16'($urandom);
                        2: ready_mask = 16'h00FF;
                        default: ready_mask = 16'($urandom) & 16'($urandom);
                    endcase
                    if (ready_mask == '0)
                        ready_mask = 16'h0001;
                end
                m_ready <= ready_mask[ready_phase - 1];
                ready_phase--;
            end
        end
    end

    // Offer one byte; bursts of random length separated by random gaps
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max > 0 && $urandom_range(0, 1)) ? $urandom_range(1, gap_max) : 0;
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_stream_end <= last;
        do
            @(posedge aclk);
        while (!s_ready);
        items_sent++;
    endtask

    // Append to the current stream; the final byte carries stream_end
    task automatic put_byte(input logic [7:0] b);
        if (stream_cnt < stream_len) begin
            send_byte(b, stream_cnt == stream_len - 1);
            stream_cnt++;
        end
    endtask

    // Template-shaped stream: blocks with random content, line breaks, some noise.
    // The first dense_len bytes are mostly line breaks.
    task automatic gen_stream(input int len, input int dense_len);
        int         r;
        int         pct;
        bit         in_code;
        logic [7:0] c;
        stream_len = len;
        stream_cnt = 0;
        in_code    = 1'b0;
        while (stream_cnt < stream_len) begin
            pct = (stream_cnt < dense_len) ? 97 : 12;
            r   = $urandom_range(0, 99);
            if (r < pct) begin
                put_byte(($urandom_range(0, 7) == 0) ? tds_pkg::CH_CR : tds_pkg::CH_LF);
            end else if (r >= 92) begin
                put_byte(8'($urandom));
            end else if (r % 3 == 0) begin
                if (in_code) begin
                    put_byte(tds_pkg::CH_PCT);
                    put_byte(tds_pkg::CH_GT);
                end else begin
                    put_byte(tds_pkg::CH_LT);
                    put_byte(tds_pkg::CH_PCT);
                    case ($urandom_range(0, 3))
                        0: c = $urandom_range(0, 1) ? tds_pkg::CH_SP : 8'($urandom_range(9, 13));
                        1: c = tds_pkg::CH_PCT;
                        2: c = 8'($urandom);
                        default: c = 8'($urandom_range(33, 126));
                    endcase
                    put_byte(c);
                end
                in_code = !in_code;
            end else begin
                if ($urandom_range(0, 9) == 0)
                    c = in_code ? tds_pkg::CH_PCT : tds_pkg::CH_LT;
                else
                    c = 8'($urandom_range(32, 126));
                put_byte(c);
            end
        end
    endtask

    // Main sequence
    initial begin
        int random_start;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data_byte   = 8'h00;
        s_stream_end  = 1'b0;
        items_sent    = 0;
        burst_left    = 0;
        gap_max       = 0;
        long_hold_req = 1'b0;

        // stream A: byte extremes, lone delimiters, code block with command,
        // paired and repeated CR LF, empty "<%%%>" block, flush on final byte
        dir_bytes = '{8'h00, 8'hFF, tds_pkg::CH_LT, 8'h78, tds_pkg::CH_LT, tds_pkg::CH_PCT,
                      8'h3D, tds_pkg::CH_PCT, 8'h79,
                      tds_pkg::CH_CR, tds_pkg::CH_LF, tds_pkg::CH_CR, tds_pkg::CH_LF,
                      tds_pkg::CH_PCT, tds_pkg::CH_GT, tds_pkg::CH_LF, tds_pkg::CH_CR,
                      tds_pkg::CH_LT, tds_pkg::CH_PCT, tds_pkg::CH_PCT, tds_pkg::CH_PCT,
                      tds_pkg::CH_GT, 8'h77,
                      // stream B: whitespace after opener, '%' on the final byte
                      tds_pkg::CH_LT, tds_pkg::CH_PCT, tds_pkg::CH_TAB, tds_pkg::CH_PCT,
                      // stream C: '<' on the final byte
                      tds_pkg::CH_LT};

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_bytes[i])
            send_byte(dir_bytes[i], i == 22 || i == 26 || i == DIR_N - 1);

        // one stream that opens with a dense run of line breaks
        gap_max = 3;
        gen_stream(DENSE_LEN + 16, DENSE_LEN);

        // random streams with varying gaps, starting against a long result-side hold-off
        gap_max       = 0;
        long_hold_req = 1'b1;
        random_start  = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: gap_max = 0;
                1: gap_max = 2;
                2: gap_max = 6;
                default: gap_max = 12;
            endcase
            gen_stream($urandom_range(4, 40), 0);
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
